@@ rtl/scw_pkg.sv @@
// Shared types and constants for the window size constrainer.
// No dependencies; imported by scw_div, window_size_constrainer_top and the testbench.
`timescale 1ns / 1ps
`default_nettype none
package scw_pkg;

  localparam int DIM_BITS     = 16;
  localparam int PROD_BITS    = 2 * DIM_BITS;
  localparam int CFG_W        = 2 * DIM_BITS;
  localparam int CFG_IDX_BITS = 3;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_HINT_FLAGS = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_SIZE   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_SIZE   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_RESIZE_INC = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_ASPECT = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_ASPECT = 3'd5;

  // hint flag bits
  localparam int FLAG_ASPECT = 0;
  localparam int FLAG_STEP   = 1;
  localparam int FLAG_MAX    = 2;
  localparam int FLAG_BITS   = 3;

  typedef logic [DIM_BITS-1:0]  dim_t;
  typedef logic [PROD_BITS-1:0] prod_t;

  typedef struct packed {
    dim_t req_width;
    dim_t req_height;
    logic enforce_minimum;
  } scw_in_t;

  typedef struct packed {
    dim_t out_width;
    dim_t out_height;
  } scw_out_t;

  // per-item state that rides along the pipeline
  typedef struct packed {
    dim_t w;
    dim_t h;
    dim_t lim_w;
    dim_t lim_h;
    logic act;    // aspect step applies to this item
    logic fire;   // current correction / snap is taken
    logic need2;  // second division of a fit is used
  } scw_ctx_t;

  typedef struct packed {
    scw_ctx_t ctx;
    prod_t    num;
    dim_t     den;
  } scw_req_t;

endpackage
`default_nettype wire

@@ rtl/scw_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with item state sideband.
// Depends on scw_pkg. Assumes num[31:16] < den when the quotient is used.
`timescale 1ns / 1ps
`default_nettype none
module scw_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  scw_pkg::prod_t   in_num,
  input  scw_pkg::dim_t    in_den,
  input  scw_pkg::scw_ctx_t in_ctx,
  output logic             out_valid,
  output scw_pkg::dim_t    out_quo,
  output scw_pkg::dim_t    out_rem,
  output scw_pkg::scw_ctx_t out_ctx
);
  import scw_pkg::*;

  logic     v_r   [DIM_BITS];
  dim_t     r_r   [DIM_BITS];
  dim_t     nq_r  [DIM_BITS];
  dim_t     den_r [DIM_BITS];
  scw_ctx_t ctx_r [DIM_BITS];

  for (genvar g = 0; g < DIM_BITS; g++) begin : g_stage
    logic                v_src;
    dim_t                r_src;
    dim_t                nq_src;
    dim_t                d_src;
    scw_ctx_t            c_src;
    logic [DIM_BITS:0]   t;
    logic [DIM_BITS:0]   diff;
    logic                ge;
    dim_t                r_nxt;
    dim_t                nq_nxt;

    if (g == 0) begin : g_first
      assign v_src  = in_valid;
      assign r_src  = in_num[PROD_BITS-1:DIM_BITS];
      assign nq_src = in_num[DIM_BITS-1:0];
      assign d_src  = in_den;
      assign c_src  = in_ctx;
    end else begin : g_next
      assign v_src  = v_r[g-1];
      assign r_src  = r_r[g-1];
      assign nq_src = nq_r[g-1];
      assign d_src  = den_r[g-1];
      assign c_src  = ctx_r[g-1];
    end

    assign t      = {r_src, nq_src[DIM_BITS-1]};
    assign ge     = t >= {1'b0, d_src};
    assign diff   = t - {1'b0, d_src};
    assign r_nxt  = ge ? diff[DIM_BITS-1:0] : t[DIM_BITS-1:0];
    assign nq_nxt = {nq_src[DIM_BITS-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[g]   <= r_nxt;
        nq_r[g]  <= nq_nxt;
        den_r[g] <= d_src;
        ctx_r[g] <= c_src;
      end
    end
  end

  assign out_valid = v_r[DIM_BITS-1];
  assign out_quo   = nq_r[DIM_BITS-1];
  assign out_rem   = r_r[DIM_BITS-1];
  assign out_ctx   = ctx_r[DIM_BITS-1];

endmodule
`default_nettype wire

@@ rtl/window_size_constrainer_top.sv @@
// Window size constrainer: top level, configuration registers and pipeline control.
// Depends on scw_pkg and scw_div.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   in_*  : request word (width, height, enforce_minimum), taken when
//           in_valid && !in_stall.
//   out_* : constrained size word, taken when out_valid && !out_stall.
//   cfg_* : register write port, cfg_we with cfg_idx/cfg_data; write only
//           while the pipeline is empty. Indexes past the list are ignored.
// Throughput: one word per cycle while no stall holds the pipeline. Depth: six
//   16-stage dividers (two per aspect fit, one per axis for the resize step)
//   set the depth, plus ten stages of compare, multiply and select logic
//   around them (106 register stages).
// Flow: raise to minimum, max-ratio fit, min-ratio fit, resize snap (width
//   then height), maximum clamp.
// Stall: the pipeline advances as a whole. While a result sits in the output
//   register and out_stall is high, every stage holds and in_stall is high;
//   bubbles in flight are never dropped or duplicated.
// Reset (rst_n low, sync): all valid bits clear, registers take their
//   defaults (flags 0, min 0, max all ones, steps and ratios 1/1).
module window_size_constrainer_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  scw_pkg::scw_in_t                     in_word,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output scw_pkg::scw_out_t                    out_word,
  input  logic                                 cfg_we,
  input  logic [scw_pkg::CFG_IDX_BITS-1:0]     cfg_idx,
  input  logic [scw_pkg::CFG_W-1:0]            cfg_data
);
  import scw_pkg::*;

  // ---------------- configuration registers ----------------
  logic [FLAG_BITS-1:0] hint_flags_r;
  logic [CFG_W-1:0]     min_size_r;
  logic [CFG_W-1:0]     max_size_r;
  logic [CFG_W-1:0]     resize_inc_r;
  logic [CFG_W-1:0]     min_aspect_r;
  logic [CFG_W-1:0]     max_aspect_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hint_flags_r <= '0;
      min_size_r   <= '0;
      max_size_r   <= '1;
      resize_inc_r <= {DIM_BITS'(1), DIM_BITS'(1)};
      min_aspect_r <= {DIM_BITS'(1), DIM_BITS'(1)};
      max_aspect_r <= {DIM_BITS'(1), DIM_BITS'(1)};
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_HINT_FLAGS: hint_flags_r <= cfg_data[FLAG_BITS-1:0];
        REG_MIN_SIZE:   min_size_r   <= cfg_data;
        REG_MAX_SIZE:   max_size_r   <= cfg_data;
        REG_RESIZE_INC: resize_inc_r <= cfg_data;
        REG_MIN_ASPECT: min_aspect_r <= cfg_data;
        REG_MAX_ASPECT: max_aspect_r <= cfg_data;
        default: ;
      endcase
    end
  end

  dim_t mw, mh, xw, xh, iw, ih, mnx, mny, mxx, mxy;
  assign mw  = min_size_r[DIM_BITS-1:0];
  assign mh  = min_size_r[CFG_W-1:DIM_BITS];
  assign xw  = max_size_r[DIM_BITS-1:0];
  assign xh  = max_size_r[CFG_W-1:DIM_BITS];
  assign iw  = resize_inc_r[DIM_BITS-1:0];
  assign ih  = resize_inc_r[CFG_W-1:DIM_BITS];
  assign mnx = min_aspect_r[DIM_BITS-1:0];
  assign mny = min_aspect_r[CFG_W-1:DIM_BITS];
  assign mxx = max_aspect_r[DIM_BITS-1:0];
  assign mxy = max_aspect_r[CFG_W-1:DIM_BITS];

  // first half of a fit: pick the first quotient, check it against the
  // starting size, and set up the second division if it overshoots
  function automatic scw_req_t fit_mid(scw_ctx_t c, dim_t q, dim_t ax, dim_t ay);
    scw_req_t r;
    r           = '0;
    r.ctx       = c;
    r.ctx.need2 = 1'b0;
    if (ax > ay) begin
      r.num = PROD_BITS'(c.lim_h) * PROD_BITS'(ax);
      r.den = ay;
      if (c.fire) begin
        if (c.lim_h != '0 && q > c.lim_h) begin
          r.ctx.h     = c.lim_h;
          r.ctx.need2 = 1'b1;
        end else begin
          r.ctx.h = q;
        end
      end
    end else begin
      r.num = PROD_BITS'(c.lim_w) * PROD_BITS'(ay);
      r.den = ax;
      if (c.fire) begin
        if (c.lim_w != '0 && q > c.lim_w) begin
          r.ctx.w     = c.lim_w;
          r.ctx.need2 = 1'b1;
        end else begin
          r.ctx.w = q;
        end
      end
    end
    return r;
  endfunction

  function automatic scw_ctx_t fit_end(scw_ctx_t c, dim_t q, dim_t ax, dim_t ay);
    scw_ctx_t r;
    r = c;
    if (c.need2) begin
      if (ax > ay) begin
        r.w = q;
      end else begin
        r.h = q;
      end
    end
    return r;
  endfunction

  // ---------------- pipeline control ----------------
  logic     en;
  logic     out_valid_r;
  scw_out_t out_word_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // stage 0: raise to minimum, decide whether the aspect step applies
  logic     v0_r;
  scw_ctx_t c0_r, c0_nxt;

  always_comb begin
    c0_nxt       = '0;
    c0_nxt.w     = in_word.req_width;
    c0_nxt.h     = in_word.req_height;
    if (in_word.enforce_minimum) begin
      if (c0_nxt.w < mw) c0_nxt.w = mw;
      if (c0_nxt.h < mh) c0_nxt.h = mh;
    end
    c0_nxt.lim_w = c0_nxt.w;
    c0_nxt.lim_h = c0_nxt.h;
    c0_nxt.act   = hint_flags_r[FLAG_ASPECT] &&
                   (in_word.enforce_minimum ||
                    (in_word.req_width >= mw && in_word.req_height >= mh));
  end

  // stage 1: ratio test against the maximum aspect
  logic     v1_r;
  scw_ctx_t c1_r, c1_nxt;
  prod_t    pw1_r, ph1_r, pw1_nxt, ph1_nxt;

  always_comb begin
    pw1_nxt     = PROD_BITS'(c0_r.w) * PROD_BITS'(mxy);
    ph1_nxt     = PROD_BITS'(c0_r.h) * PROD_BITS'(mxx);
    c1_nxt      = c0_r;
    c1_nxt.fire = c0_r.act && (pw1_nxt > ph1_nxt) && mxx != '0 && mxy != '0;
  end

  logic     da1_v;
  dim_t     da1_q;
  scw_ctx_t da1_c;

  scw_div u_div_a1 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v1_r),
    .in_num((mxx > mxy) ? pw1_r : ph1_r),
    .in_den((mxx > mxy) ? mxx : mxy),
    .in_ctx(c1_r),
    .out_valid(da1_v), .out_quo(da1_q), .out_rem(), .out_ctx(da1_c)
  );

  // stage 2: first half of the max-ratio fit
  logic     v2_r;
  scw_req_t q2_r, q2_nxt;
  assign q2_nxt = fit_mid(da1_c, da1_q, mxx, mxy);

  logic     db1_v;
  dim_t     db1_q;
  scw_ctx_t db1_c;

  scw_div u_div_b1 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v2_r), .in_num(q2_r.num), .in_den(q2_r.den), .in_ctx(q2_r.ctx),
    .out_valid(db1_v), .out_quo(db1_q), .out_rem(), .out_ctx(db1_c)
  );

  // stage 3: close the max-ratio fit
  logic     v3_r;
  scw_ctx_t c3_r, c3_nxt;
  assign c3_nxt = fit_end(db1_c, db1_q, mxx, mxy);

  // stage 4: ratio test against the minimum aspect, on the updated size
  logic     v4_r;
  scw_ctx_t c4_r, c4_nxt;
  prod_t    pw4_r, ph4_r, pw4_nxt, ph4_nxt;

  always_comb begin
    pw4_nxt     = PROD_BITS'(c3_r.w) * PROD_BITS'(mny);
    ph4_nxt     = PROD_BITS'(c3_r.h) * PROD_BITS'(mnx);
    c4_nxt      = c3_r;
    c4_nxt.fire = c3_r.act && (pw4_nxt < ph4_nxt) && mnx != '0 && mny != '0;
  end

  logic     da2_v;
  dim_t     da2_q;
  scw_ctx_t da2_c;

  scw_div u_div_a2 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v4_r),
    .in_num((mnx > mny) ? pw4_r : ph4_r),
    .in_den((mnx > mny) ? mnx : mny),
    .in_ctx(c4_r),
    .out_valid(da2_v), .out_quo(da2_q), .out_rem(), .out_ctx(da2_c)
  );

  // stage 5: first half of the min-ratio fit
  logic     v5_r;
  scw_req_t q5_r, q5_nxt;
  assign q5_nxt = fit_mid(da2_c, da2_q, mnx, mny);

  logic     db2_v;
  dim_t     db2_q;
  scw_ctx_t db2_c;

  scw_div u_div_b2 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v5_r), .in_num(q5_r.num), .in_den(q5_r.den), .in_ctx(q5_r.ctx),
    .out_valid(db2_v), .out_quo(db2_q), .out_rem(), .out_ctx(db2_c)
  );

  // stage 6: close the min-ratio fit
  logic     v6_r;
  scw_ctx_t c6_r, c6_nxt;
  assign c6_nxt = fit_end(db2_c, db2_q, mnx, mny);

  // stage 7: width snap setup; the remainder of (w - min) comes off w
  logic     v7_r;
  scw_req_t q7_r, q7_nxt;

  always_comb begin
    q7_nxt          = '0;
    q7_nxt.ctx      = c6_r;
    q7_nxt.ctx.fire = hint_flags_r[FLAG_STEP] && iw != '0 && c6_r.w > mw;
    q7_nxt.num      = PROD_BITS'(c6_r.w - mw);
    q7_nxt.den      = iw;
  end

  logic     dw_v;
  dim_t     dw_rem;
  scw_ctx_t dw_c;

  scw_div u_div_w (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v7_r), .in_num(q7_r.num), .in_den(q7_r.den), .in_ctx(q7_r.ctx),
    .out_valid(dw_v), .out_quo(), .out_rem(dw_rem), .out_ctx(dw_c)
  );

  // stage 8: apply width snap, set up height snap
  logic     v8_r;
  scw_req_t q8_r, q8_nxt;

  always_comb begin
    q8_nxt     = '0;
    q8_nxt.ctx = dw_c;
    if (dw_c.fire) begin
      q8_nxt.ctx.w = dw_c.w - dw_rem;
    end
    q8_nxt.ctx.fire = hint_flags_r[FLAG_STEP] && ih != '0 && dw_c.h > mh;
    q8_nxt.num      = PROD_BITS'(dw_c.h - mh);
    q8_nxt.den      = ih;
  end

  logic     dh_v;
  dim_t     dh_rem;
  scw_ctx_t dh_c;

  scw_div u_div_h (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v8_r), .in_num(q8_r.num), .in_den(q8_r.den), .in_ctx(q8_r.ctx),
    .out_valid(dh_v), .out_quo(), .out_rem(dh_rem), .out_ctx(dh_c)
  );

  // output stage: apply height snap, clamp to maximum
  scw_out_t out_word_nxt;
  dim_t     fin_h;

  always_comb begin
    fin_h = dh_c.fire ? (dh_c.h - dh_rem) : dh_c.h;
    out_word_nxt.out_width  = dh_c.w;
    out_word_nxt.out_height = fin_h;
    if (hint_flags_r[FLAG_MAX]) begin
      if (dh_c.w > xw) out_word_nxt.out_width  = xw;
      if (fin_h > xh)  out_word_nxt.out_height = xh;
    end
  end

  // ---------------- stage registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      v8_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v0_r        <= in_valid;
      v1_r        <= v0_r;
      v2_r        <= da1_v;
      v3_r        <= db1_v;
      v4_r        <= v3_r;
      v5_r        <= da2_v;
      v6_r        <= db2_v;
      v7_r        <= v6_r;
      v8_r        <= dw_v;
      out_valid_r <= dh_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c0_r       <= c0_nxt;
      c1_r       <= c1_nxt;
      pw1_r      <= pw1_nxt;
      ph1_r      <= ph1_nxt;
      q2_r       <= q2_nxt;
      c3_r       <= c3_nxt;
      c4_r       <= c4_nxt;
      pw4_r      <= pw4_nxt;
      ph4_r      <= ph4_nxt;
      q5_r       <= q5_nxt;
      c6_r       <= c6_nxt;
      q7_r       <= q7_nxt;
      q8_r       <= q8_nxt;
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // ---------------- assertions ----------------
  // a waiting result must freeze the input side
  a_stall_back : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("input taken while output stalled");

  // a frozen pipeline keeps its entry stage and its height-snap stage
  a_hold_entry : assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v0_r) && $stable(v8_r))
    else $error("pipeline moved while stalled");

  // a stalled result is not dropped while the pipeline is frozen
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

endmodule
`default_nettype wire

@@ tb/window_size_constrainer_top_tb.sv @@
// Testbench for window_size_constrainer_top: directed table plus random size requests,
// each result checked against a typed-in expected word or an in-bench size-hint predictor. Depends on scw_pkg.
`timescale 1ns / 1ps
module window_size_constrainer_top_tb;
  import scw_pkg::*;

  localparam int LATENCY     = 105;
  localparam int WDOG_LIMIT  = 20 * LATENCY;
  localparam int RAND_ITEMS  = 1930;
  localparam int N_SEG       = 10;
  localparam int SEG_ITEMS   = RAND_ITEMS / N_SEG;
  localparam int RUSH_SEG    = 4;
  localparam int N_DIR       = 35;

  // an index past the register list, writes to it are dropped
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd6;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t               kind;
    logic [CFG_IDX_BITS-1:0] idx;
    logic [CFG_W-1:0]        data;
    scw_in_t                 word;
    logic                    chk;    // expected word typed in below
    scw_out_t                exp;
  } row_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  scw_in_t  in_word;
  logic     out_valid;
  logic     out_stall;
  scw_out_t out_word;
  logic     cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_idx;
  logic [CFG_W-1:0]        cfg_data;

  window_size_constrainer_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  // predictor's own copy of the hint registers
  logic [FLAG_BITS-1:0] hints;
  logic [31:0] min_sz, max_sz, step_sz, min_ar, max_ar;

  scw_out_t size_q[$];   // expected constrained sizes, oldest first
  scw_out_t got_exp;
  int  n_mismatch  = 0;
  int  idle_cycles = 0;
  logic rush;            // no idling on either side
  row_t dir_tab [N_DIR];

  // ---------------- predictor ----------------
  function automatic logic [63:0] lo_half(input logic [CFG_W-1:0] v);
    return 64'(v[DIM_BITS-1:0]);
  endfunction

  function automatic logic [63:0] hi_half(input logic [CFG_W-1:0] v);
    return 64'(v[CFG_W-1:DIM_BITS]);
  endfunction

  function automatic void fit_ratio(input logic [63:0] lim_w, lim_h, ax, ay,
                                    inout logic [63:0] w, h);
    logic [63:0] cw, ch;
    cw = w;
    ch = h;
    if (ax != '0 && ay != '0) begin
      if (ax > ay) begin
        ch = (cw * ay) / ax;
        if (lim_h != '0 && ch > lim_h) begin
          ch = lim_h;
          cw = (ch * ax) / ay;
        end
      end else begin
        cw = (ch * ax) / ay;
        if (lim_w != '0 && cw > lim_w) begin
          cw = lim_w;
          ch = (cw * ay) / ax;
        end
      end
    end
    w = cw;
    h = ch;
  endfunction

  function automatic void aspect_step(inout logic [63:0] w, h);
    logic [63:0] lim_w, lim_h, mnx, mny, mxx, mxy;
    lim_w = w;
    lim_h = h;
    mnx   = lo_half(min_ar);
    mny   = hi_half(min_ar);
    mxx   = lo_half(max_ar);
    mxy   = hi_half(max_ar);
    if (hints[FLAG_ASPECT]) begin
      if (w * mxy > h * mxx) fit_ratio(lim_w, lim_h, mxx, mxy, w, h);
      if (w * mny < h * mnx) fit_ratio(lim_w, lim_h, mnx, mny, w, h);
    end
  endfunction

  function automatic scw_out_t predict(input scw_in_t x);
    logic [63:0] w, h, mw, mh, iw, ih, xw, xh, dmax;
    scw_out_t r;
    w    = 64'(x.req_width);
    h    = 64'(x.req_height);
    mw   = lo_half(min_sz);
    mh   = hi_half(min_sz);
    dmax = (64'd1 << DIM_BITS) - 64'd1;
    if (x.enforce_minimum) begin
      if (w < mw) w = mw;
      if (h < mh) h = mh;
      aspect_step(w, h);
    end else if (w >= mw && h >= mh) begin
      aspect_step(w, h);
    end
    if (hints[FLAG_STEP]) begin
      iw = lo_half(step_sz);
      ih = hi_half(step_sz);
      if (iw != '0 && w > mw) w = ((w - mw) / iw) * iw + mw;
      if (ih != '0 && h > mh) h = ((h - mh) / ih) * ih + mh;
    end
    if (hints[FLAG_MAX]) begin
      xw = lo_half(max_sz);
      xh = hi_half(max_sz);
      if (w > xw) w = xw;
      if (h > xh) h = xh;
    end
    if (w > dmax) w = dmax;
    if (h > dmax) h = dmax;
    r.out_width  = w[DIM_BITS-1:0];
    r.out_height = h[DIM_BITS-1:0];
    return r;
  endfunction

  // ---------------- table rows ----------------
  function automatic row_t row_item(input dim_t w, input dim_t h, input logic e,
                                    input logic chk, input dim_t ew, input dim_t eh);
    row_t r;
    r.kind                = ROW_ITEM;
    r.idx                 = REG_HINT_FLAGS;
    r.data                = '0;
    r.word.req_width      = w;
    r.word.req_height     = h;
    r.word.enforce_minimum = e;
    r.chk                 = chk;
    r.exp.out_width       = ew;
    r.exp.out_height      = eh;
    return r;
  endfunction

  function automatic row_t row_cfg(input logic [CFG_IDX_BITS-1:0] idx,
                                   input logic [CFG_W-1:0] data);
    row_t r;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.data = data;
    r.word = '0;
    r.chk  = 1'b0;
    r.exp  = '0;
    return r;
  endfunction

  // ---------------- random values ----------------
  function automatic dim_t rand_size();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel == 0) return '0;
    if (sel < 5) return dim_t'($urandom_range(511));
    if (sel < 8) return dim_t'($urandom_range(8191));
    return dim_t'($urandom_range(65535));
  endfunction

  function automatic dim_t rand_term();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel == 0) return '0;
    if (sel < 8) return dim_t'($urandom_range(20, 1));
    return dim_t'($urandom_range(65535));
  endfunction

  // ---------------- clock ----------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------- driving ----------------
  // waits for the pipeline to empty, then writes one register
  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_W-1:0] data);
    in_valid <= 1'b0;
    @(posedge clk);
    while (size_q.size() != 0) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_HINT_FLAGS: hints   = data[FLAG_BITS-1:0];
      REG_MIN_SIZE:   min_sz  = data;
      REG_MAX_SIZE:   max_sz  = data;
      REG_RESIZE_INC: step_sz = data;
      REG_MIN_ASPECT: min_ar  = data;
      REG_MAX_ASPECT: max_ar  = data;
      default: ;
    endcase
  endtask

  // offers one word, holds it through stalls, queues its expected result
  task automatic send_item(input scw_in_t word, input logic chk, input scw_out_t exp_word);
    scw_out_t e;
    e = chk ? exp_word : predict(word);
    if (!rush && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 22) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    size_q.push_back(e);
  endtask

  task automatic random_config();
    cfg_write(REG_HINT_FLAGS, CFG_W'($urandom_range(7)));
    cfg_write(REG_MIN_SIZE,   {dim_t'($urandom_range(300)), dim_t'($urandom_range(300))});
    cfg_write(REG_MAX_SIZE,   {rand_size(), rand_size()});
    cfg_write(REG_RESIZE_INC, {rand_term(), rand_term()});
    cfg_write(REG_MIN_ASPECT, {rand_term(), rand_term()});
    cfg_write(REG_MAX_ASPECT, {rand_term(), rand_term()});
    if ($urandom_range(3) == 0) cfg_write(REG_UNUSED, CFG_W'($urandom));
  endtask

  // receiver idles at random except in the rush stretch
  always @(posedge clk) begin
    out_stall <= !rush && ($urandom_range(99) < 22);
  end

  // ---------------- checking ----------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (size_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected word: got %0d x %0d",
                   out_word.out_width, out_word.out_height);
      end else begin
        got_exp = size_q.pop_front();
        if (got_exp !== out_word) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: expected %0d x %0d, got %0d x %0d",
                     got_exp.out_width, got_exp.out_height,
                     out_word.out_width, out_word.out_height);
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // ---------------- stimulus ----------------
  initial begin
    scw_in_t word;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_word  = '0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    rush     = 1'b0;
    hints    = '0;
    min_sz   = 32'h0000_0000;
    max_sz   = 32'hFFFF_FFFF;
    step_sz  = 32'h0001_0001;
    min_ar   = 32'h0001_0001;
    max_ar   = 32'h0001_0001;

    dir_tab = '{
      // reset defaults pass the request through
      row_item(16'd100,   16'd50,    1'b0, 1'b1, 16'd100,   16'd50),
      row_item(16'd0,     16'd0,     1'b1, 1'b1, 16'd0,     16'd0),
      row_item(16'd65535, 16'd65535, 1'b0, 1'b1, 16'd65535, 16'd65535),
      // minimum 30 x 20
      row_cfg(REG_MIN_SIZE, 32'h0014_001E),
      row_item(16'd10,    16'd10,    1'b1, 1'b1, 16'd30,    16'd20),
      row_item(16'd10,    16'd10,    1'b0, 1'b1, 16'd10,    16'd10),
      // maximum 300 x 200, clamp only
      row_cfg(REG_MAX_SIZE, 32'h00C8_012C),
      row_cfg(REG_HINT_FLAGS, 32'd4),
      row_item(16'd1000,  16'd1000,  1'b0, 1'b1, 16'd300,   16'd200),
      row_item(16'd1000,  16'd5,     1'b1, 1'b1, 16'd300,   16'd20),
      // resize steps 10 x 7
      row_cfg(REG_RESIZE_INC, 32'h0007_000A),
      row_cfg(REG_HINT_FLAGS, 32'd6),
      row_item(16'd57,    16'd50,    1'b0, 1'b0, 16'd0,     16'd0),
      row_item(16'd30,    16'd20,    1'b0, 1'b0, 16'd0,     16'd0),
      // all hints, square aspect
      row_cfg(REG_HINT_FLAGS, 32'd7),
      row_item(16'd200,   16'd100,   1'b0, 1'b0, 16'd0,     16'd0),
      row_item(16'd100,   16'd200,   1'b1, 1'b0, 16'd0,     16'd0),
      // aspect between 1:2 and 4:3
      row_cfg(REG_MAX_ASPECT, 32'h0003_0004),
      row_cfg(REG_MIN_ASPECT, 32'h0002_0001),
      row_item(16'd400,   16'd100,   1'b0, 1'b0, 16'd0,     16'd0),
      row_item(16'd40,    16'd300,   1'b0, 1'b0, 16'd0,     16'd0),
      row_item(16'd5,     16'd300,   1'b0, 1'b0, 16'd0,     16'd0),
      row_item(16'd5,     16'd300,   1'b1, 1'b0, 16'd0,     16'd0),
      // zero numerator skips the max-ratio fit
      row_cfg(REG_MAX_ASPECT, 32'h0003_0000),
      row_item(16'd400,   16'd100,   1'b0, 1'b0, 16'd0,     16'd0),
      // write past the register list is dropped
      row_cfg(REG_UNUSED, 32'hFFFF_FFFF),
      row_item(16'd400,   16'd100,   1'b0, 1'b0, 16'd0,     16'd0),
      // zero width step leaves width unsnapped
      row_cfg(REG_RESIZE_INC, 32'h0005_0000),
      row_item(16'd123,   16'd77,    1'b0, 1'b0, 16'd0,     16'd0),
      // extreme ratios and full range
      row_cfg(REG_MAX_ASPECT, 32'h0001_FFFF),
      row_cfg(REG_MIN_ASPECT, 32'hFFFF_0001),
      row_cfg(REG_MAX_SIZE, 32'hFFFF_FFFF),
      row_item(16'd65535, 16'd1,     1'b0, 1'b0, 16'd0,     16'd0),
      row_item(16'd1,     16'd65535, 1'b1, 1'b0, 16'd0,     16'd0),
      row_item(16'd65535, 16'd65535, 1'b1, 1'b0, 16'd0,     16'd0)
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        cfg_write(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        send_item(dir_tab[i].word, dir_tab[i].chk, dir_tab[i].exp);
      end
    end

    for (int s = 0; s < N_SEG; s++) begin
      random_config();
      rush = (s == RUSH_SEG);
      for (int k = 0; k < SEG_ITEMS; k++) begin
        word.req_width       = rand_size();
        word.req_height      = rand_size();
        word.enforce_minimum = 1'($urandom_range(1));
        send_item(word, 1'b0, '0);
      end
    end

    // let every result drain
    rush = 1'b0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (size_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (n_mismatch == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ window_size_constrainer_top.f @@
rtl/scw_pkg.sv
rtl/scw_div.sv
rtl/window_size_constrainer_top.sv
tb/window_size_constrainer_top_tb.sv
